[src/cron_expression_parse_match_defines.svh]
// Assertion macros used by the cron parser controller.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef CRON_EXPRESSION_PARSE_MATCH_DEFINES_SVH
`define CRON_EXPRESSION_PARSE_MATCH_DEFINES_SVH

// a in this cycle implies b in the next cycle
`define CEPM_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("cepm check failed");

// a implies b in the same cycle
`define CEPM_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("cepm check failed");

`endif

[src/cepm_pkg.sv]
// Package for the cron expression parser/matcher: payload types, controller
// command and status structs, parser constants and helper functions.
package cepm_pkg;

    localparam int unsigned MAX_EXPR_CHARS_DEF = 255;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic       last_char;
        logic [5:0] minute_value;
        logic [4:0] hour_value;
        logic [3:0] month_index;
        logic [4:0] mday_value;
        logic [2:0] wday_value;
    } t_in_req;

    typedef struct packed {
        logic [1:0] parse_status;
        logic       match_hit;
    } t_out_rsp;

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic REQ_CHAR  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [2:0] PH_FIELD   = 3'd0;
    localparam logic [2:0] PH_TERM    = 3'd1;
    localparam logic [2:0] PH_FIRST   = 3'd2;
    localparam logic [2:0] PH_STAR    = 3'd3;
    localparam logic [2:0] PH_DASH    = 3'd4;
    localparam logic [2:0] PH_LAST    = 3'd5;
    localparam logic [2:0] PH_SLASH   = 3'd6;
    localparam logic [2:0] PH_STEP    = 3'd7;

    localparam logic [2:0] FLD_MINUTE   = 3'd0;
    localparam logic [2:0] FLD_HOUR     = 3'd1;
    localparam logic [2:0] FLD_MONTHDAY = 3'd2;
    localparam logic [2:0] FLD_MONTH    = 3'd3;
    localparam logic [2:0] FLD_WEEKDAY  = 3'd4;
    localparam logic [2:0] FLD_COUNT    = 3'd5;

    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [6:0] SAT_VALUE     = 7'd127;
    localparam logic [6:0] WEEKDAY_ALIAS = 7'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_WALK,
        S_FINISH,
        S_FDONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic eval;
        logic close_start;
        logic walk;
        logic fin_eval;
        logic fin_done;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic last_char;
        logic do_close;
        logic close_ok;
        logic walk_done;
        logic fin_close;
    } t_status;

    function automatic logic [6:0] bound_lo(input logic [2:0] fld);
        logic [6:0] r;
        unique case (fld)
            FLD_MONTHDAY, FLD_MONTH: r = 7'd1;
            default:                 r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] bound_hi(input logic [2:0] fld);
        logic [6:0] r;
        unique case (fld)
            FLD_MINUTE:   r = 7'd59;
            FLD_HOUR:     r = 7'd23;
            FLD_MONTHDAY: r = 7'd31;
            FLD_MONTH:    r = 7'd12;
            default:      r = 7'd7;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] sat_digit(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] v;
        v = 11'(acc) * 11'd10 + 11'(d);
        return (v > 11'(SAT_VALUE)) ? SAT_VALUE : v[6:0];
    endfunction

endpackage

[src/cron_expression_parse_match.sv]
// Sequence: a query or a plain character is latched, evaluated and loaded into the output
// register; a character closing a term adds a term check and, if the term is valid, a walk
// over each of its values (up to 60), and the last character adds the finish and commit
// steps plus, for a final open term, a term check and its walk.
// One request in flight; a new one is taken while the previous result waits.
// Synchronous active-low reset clears the committed expression and the parser.
module cron_expression_parse_match #(
    parameter int unsigned MAX_EXPR_CHARS = cepm_pkg::MAX_EXPR_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cepm_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cepm_pkg::t_out_rsp o_out_data
);

    cepm_pkg::t_cmd    cmd;
    cepm_pkg::t_status status;

    cepm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cepm_dp #(
        .MAX_EXPR_CHARS (MAX_EXPR_CHARS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

[src/cepm_ctrl.sv]
// Controller FSM for the cron parser: sequences evaluate, term check, value
// walk, finish and result hand-off. Uses cepm_pkg and the defines header.
`include "cron_expression_parse_match_defines.svh"

module cepm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cepm_pkg::t_status i_status,
    output cepm_pkg::t_cmd   o_cmd
);

    cepm_pkg::t_state r_state, n_state;
    logic             r_fin, n_fin;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cepm_pkg::S_IDLE;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fin       = r_fin;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            cepm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_fin       = 1'b0;
                    n_state     = cepm_pkg::S_EVAL;
                end
            end
            cepm_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.is_query) begin
                    n_state = cepm_pkg::S_OUT;
                end else if (i_status.do_close) begin
                    n_state = cepm_pkg::S_CHECK;
                end else if (i_status.last_char) begin
                    n_state = cepm_pkg::S_FINISH;
                end else begin
                    n_state = cepm_pkg::S_OUT;
                end
            end
            cepm_pkg::S_CHECK: begin
                o_cmd.close_start = 1'b1;
                if (i_status.close_ok) begin
                    n_state = cepm_pkg::S_WALK;
                end else if (r_fin) begin
                    n_state = cepm_pkg::S_FDONE;
                end else if (i_status.last_char) begin
                    n_state = cepm_pkg::S_FINISH;
                end else begin
                    n_state = cepm_pkg::S_OUT;
                end
            end
            cepm_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) begin
                    if (r_fin) begin
                        n_state = cepm_pkg::S_FDONE;
                    end else if (i_status.last_char) begin
                        n_state = cepm_pkg::S_FINISH;
                    end else begin
                        n_state = cepm_pkg::S_OUT;
                    end
                end
            end
            cepm_pkg::S_FINISH: begin
                o_cmd.fin_eval = 1'b1;
                if (i_status.fin_close) begin
                    n_fin   = 1'b1;
                    n_state = cepm_pkg::S_CHECK;
                end else begin
                    n_state = cepm_pkg::S_FDONE;
                end
            end
            cepm_pkg::S_FDONE: begin
                o_cmd.fin_done = 1'b1;
                n_state        = cepm_pkg::S_OUT;
            end
            cepm_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = cepm_pkg::S_IDLE;
                end
            end
            default: n_state = cepm_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == cepm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    `CEPM_ASSERT_NEXT(a_accept_eval, i_in_valid && o_in_ready, r_state == cepm_pkg::S_EVAL)
    `CEPM_ASSERT_NEXT(a_out_hold, r_out_valid && !i_out_ready, r_out_valid)
    `CEPM_ASSERT_NEXT(a_walk_fin, r_fin && r_state == cepm_pkg::S_WALK,
        r_state == cepm_pkg::S_WALK || r_state == cepm_pkg::S_FDONE)
    `CEPM_ASSERT_NOW(a_fin_last, r_fin, i_status.last_char || r_state == cepm_pkg::S_IDLE)

endmodule

[src/cepm_dp.sv]
// Datapath for the cron parser: item latch, parser registers, pending and
// committed masks, term value walker and query match. Uses cepm_pkg.
module cepm_dp #(
    parameter int unsigned MAX_EXPR_CHARS = cepm_pkg::MAX_EXPR_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cepm_pkg::t_in_req i_in_data,
    input  cepm_pkg::t_cmd    i_cmd,
    output cepm_pkg::t_status o_status,
    output cepm_pkg::t_out_rsp o_out_data
);

    localparam int unsigned CW = $clog2(MAX_EXPR_CHARS + 2);

    cepm_pkg::t_in_req  r_item;
    cepm_pkg::t_out_rsp r_res, r_out;

    logic [59:0] r_min, r_pmin;
    logic [23:0] r_hr, r_phr;
    logic [30:0] r_md, r_pmd;
    logic [11:0] r_mo, r_pmo;
    logic [6:0]  r_wd, r_pwd;
    logic        r_any_md, r_any_wd;
    logic [1:0]  r_wild;
    logic [2:0]  r_field;
    logic [CW-1:0] r_count;
    logic [2:0]  r_phase;
    logic [6:0]  r_rf, r_rl, r_ss;
    logic [2:0]  r_flags;
    logic        r_err;
    logic        r_comma;
    logic [6:0]  r_v, r_last, r_step;

    logic [7:0]  c;
    logic        ws, dig;
    logic [3:0]  d;
    logic [CW-1:0] count_n;
    logic        over, skip;
    logic        tc_ok, tc_close;
    logic [2:0]  tc_phase, tc_flags;
    logic [6:0]  tc_rf, tc_rl, tc_ss;
    logic [6:0]  lo, hi, first, last, step, idx;
    logic        close_ok, walk_done, fin_bad, commit_ok, hit, dmh, dwh, base_hit;
    logic [63:0] min64;
    logic [31:0] hr32, md32;
    logic [15:0] mo16;
    logic [7:0]  wd8;
    logic [4:0]  dm_idx;

    assign c   = r_item.char_code;
    assign ws  = (c == cepm_pkg::CH_SPACE) || (c >= cepm_pkg::CH_TAB && c <= cepm_pkg::CH_CR);
    assign dig = (c >= cepm_pkg::CH_ZERO) && (c <= cepm_pkg::CH_NINE);
    assign d   = dig ? 4'(c - cepm_pkg::CH_ZERO) : 4'd0;

    assign count_n = (r_count <= CW'(MAX_EXPR_CHARS)) ? r_count + CW'(1) : r_count;
    assign over    = count_n > CW'(MAX_EXPR_CHARS);
    assign skip    = r_err || over;

    always_comb begin
        tc_ok    = 1'b1;
        tc_close = 1'b0;
        tc_phase = r_phase;
        tc_flags = r_flags;
        tc_rf    = r_rf;
        tc_rl    = r_rl;
        tc_ss    = r_ss;
        unique case (r_phase)
            cepm_pkg::PH_FIELD, cepm_pkg::PH_TERM: begin
                if (r_phase == cepm_pkg::PH_FIELD && ws) begin
                    tc_ok = 1'b1;
                end else if (r_field >= cepm_pkg::FLD_COUNT) begin
                    tc_ok = 1'b0;
                end else if (dig) begin
                    tc_rf    = 7'(d);
                    tc_phase = cepm_pkg::PH_FIRST;
                end else if (c == cepm_pkg::CH_STAR) begin
                    tc_flags = r_flags | 3'b001;
                    tc_phase = cepm_pkg::PH_STAR;
                end else begin
                    tc_ok = 1'b0;
                end
            end
            cepm_pkg::PH_DASH: begin
                if (dig) begin
                    tc_rl    = 7'(d);
                    tc_phase = cepm_pkg::PH_LAST;
                end else begin
                    tc_ok = 1'b0;
                end
            end
            cepm_pkg::PH_SLASH: begin
                if (dig) begin
                    tc_ss    = 7'(d);
                    tc_phase = cepm_pkg::PH_STEP;
                end else begin
                    tc_ok = 1'b0;
                end
            end
            default: begin
                priority if (dig && r_phase == cepm_pkg::PH_FIRST) begin
                    tc_rf = cepm_pkg::sat_digit(r_rf, d);
                end else if (dig && r_phase == cepm_pkg::PH_LAST) begin
                    tc_rl = cepm_pkg::sat_digit(r_rl, d);
                end else if (dig && r_phase == cepm_pkg::PH_STEP) begin
                    tc_ss = cepm_pkg::sat_digit(r_ss, d);
                end else if (c == cepm_pkg::CH_DASH && r_phase == cepm_pkg::PH_FIRST) begin
                    tc_flags = r_flags | 3'b010;
                    tc_phase = cepm_pkg::PH_DASH;
                end else if (c == cepm_pkg::CH_SLASH && r_phase != cepm_pkg::PH_STEP) begin
                    tc_flags = r_flags | 3'b100;
                    tc_phase = cepm_pkg::PH_SLASH;
                end else if (c == cepm_pkg::CH_COMMA || ws) begin
                    tc_close = 1'b1;
                end else begin
                    tc_ok = 1'b0;
                end
            end
        endcase
    end

    assign lo = cepm_pkg::bound_lo(r_field);
    assign hi = cepm_pkg::bound_hi(r_field);

    always_comb begin
        if (r_flags[0]) begin
            first = lo;
            last  = hi;
        end else if (r_flags[1]) begin
            first = r_rf;
            last  = r_rl;
        end else begin
            first = r_rf;
            last  = r_flags[2] ? hi : r_rf;
        end
        step = r_flags[2] ? r_ss : 7'd1;
    end

    assign close_ok = (r_field < cepm_pkg::FLD_COUNT) && (step != 7'd0) &&
                      (first >= lo) && (first <= hi) && (last >= lo) && (last <= hi) &&
                      (first <= last);

    assign walk_done = (r_last - r_v) < r_step;
    always_comb begin
        if (r_field == cepm_pkg::FLD_WEEKDAY) begin
            idx = (r_v == cepm_pkg::WEEKDAY_ALIAS) ? 7'd0 : r_v;
        end else begin
            idx = r_v - lo;
        end
    end

    assign fin_bad   = r_err || r_phase == cepm_pkg::PH_TERM ||
                       r_phase == cepm_pkg::PH_DASH || r_phase == cepm_pkg::PH_SLASH;
    assign commit_ok = !r_err && (r_field == cepm_pkg::FLD_COUNT);

    assign min64  = {4'd0, r_min};
    assign hr32   = {8'd0, r_hr};
    assign mo16   = {4'd0, r_mo};
    assign md32   = {1'b0, r_md};
    assign wd8    = {1'b0, r_wd};
    assign dm_idx = r_item.mday_value - 5'd1;
    assign dmh    = (r_item.mday_value != 5'd0) && md32[dm_idx];
    assign dwh    = ({1'b0, r_item.wday_value} <= 4'd6) && wd8[r_item.wday_value];
    assign base_hit = (r_item.minute_value <= 6'd59) && (r_item.hour_value <= 5'd23) &&
                      (r_item.month_index <= 4'd11) && min64[r_item.minute_value] &&
                      hr32[r_item.hour_value] && mo16[r_item.month_index];
    always_comb begin
        priority if (r_any_md && r_any_wd) begin
            hit = base_hit;
        end else if (r_any_md) begin
            hit = base_hit && dwh;
        end else if (r_any_wd) begin
            hit = base_hit && dmh;
        end else begin
            hit = base_hit && (dmh || dwh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
            r_res  <= '0;
        end
        if (i_cmd.eval && r_item.req_type == cepm_pkg::REQ_QUERY) begin
            r_res.match_hit <= hit;
        end
        if (i_cmd.fin_done) begin
            r_res.parse_status <= commit_ok ? cepm_pkg::ST_ACCEPTED : cepm_pkg::ST_REJECTED;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
        if (i_cmd.close_start) begin
            r_v    <= first;
            r_last <= last;
            r_step <= step;
        end else if (i_cmd.walk) begin
            r_v <= r_v + r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0; r_hr <= '0; r_md <= '0; r_mo <= '0; r_wd <= '0;
            r_any_md <= 1'b0; r_any_wd <= 1'b0;
            r_pmin <= '0; r_phr <= '0; r_pmd <= '0; r_pmo <= '0; r_pwd <= '0;
            r_wild <= '0; r_field <= '0; r_count <= '0; r_phase <= cepm_pkg::PH_FIELD;
            r_rf <= '0; r_rl <= '0; r_ss <= '0; r_flags <= '0;
            r_err <= 1'b0; r_comma <= 1'b0;
        end else begin
            if (i_cmd.eval && r_item.req_type == cepm_pkg::REQ_CHAR) begin
                r_count <= count_n;
                if (skip) begin
                    r_err <= 1'b1;
                end else if (!tc_ok) begin
                    r_err <= 1'b1;
                end else if (tc_close) begin
                    r_comma <= (c == cepm_pkg::CH_COMMA);
                end else begin
                    r_phase <= tc_phase;
                    r_flags <= tc_flags;
                    r_rf    <= tc_rf;
                    r_rl    <= tc_rl;
                    r_ss    <= tc_ss;
                end
            end
            if (i_cmd.close_start) begin
                r_rf    <= '0;
                r_rl    <= '0;
                r_ss    <= '0;
                r_flags <= '0;
                if (r_flags[0] && r_field == cepm_pkg::FLD_MONTHDAY) r_wild[0] <= 1'b1;
                if (r_flags[0] && r_field == cepm_pkg::FLD_WEEKDAY)  r_wild[1] <= 1'b1;
                if (!close_ok) r_err <= 1'b1;
            end
            if (i_cmd.walk) begin
                unique case (r_field)
                    cepm_pkg::FLD_MINUTE:   r_pmin <= r_pmin | (60'd1 << idx);
                    cepm_pkg::FLD_HOUR:     r_phr  <= r_phr  | (24'd1 << idx);
                    cepm_pkg::FLD_MONTHDAY: r_pmd  <= r_pmd  | (31'd1 << idx);
                    cepm_pkg::FLD_MONTH:    r_pmo  <= r_pmo  | (12'd1 << idx);
                    default:                r_pwd  <= r_pwd  | (7'd1 << idx);
                endcase
                if (walk_done) begin
                    if (r_comma) begin
                        r_phase <= cepm_pkg::PH_TERM;
                    end else begin
                        r_field <= r_field + 3'd1;
                        r_phase <= cepm_pkg::PH_FIELD;
                    end
                end
            end
            if (i_cmd.fin_eval) begin
                r_comma <= 1'b0;
                if (fin_bad) r_err <= 1'b1;
            end
            if (i_cmd.fin_done) begin
                if (commit_ok) begin
                    r_min <= r_pmin; r_hr <= r_phr; r_md <= r_pmd;
                    r_mo <= r_pmo; r_wd <= r_pwd;
                    r_any_md <= r_wild[0];
                    r_any_wd <= r_wild[1];
                end
                r_pmin <= '0; r_phr <= '0; r_pmd <= '0; r_pmo <= '0; r_pwd <= '0;
                r_wild <= '0; r_field <= '0; r_count <= '0; r_phase <= cepm_pkg::PH_FIELD;
                r_rf <= '0; r_rl <= '0; r_ss <= '0; r_flags <= '0;
                r_err <= 1'b0; r_comma <= 1'b0;
            end
        end
    end

    assign o_status.is_query  = (r_item.req_type == cepm_pkg::REQ_QUERY);
    assign o_status.last_char = r_item.last_char;
    assign o_status.do_close  = !skip && tc_ok && tc_close;
    assign o_status.close_ok  = close_ok;
    assign o_status.walk_done = walk_done;
    assign o_status.fin_close = !fin_bad && (r_phase != cepm_pkg::PH_FIELD);
    assign o_out_data         = r_out;

endmodule
